// ===== design/fir_lowpass_31tap_q15_defines.svh =====
// ---------------------------------------------------------------------------
// fir_lowpass_31tap_q15 assertion macros
// Concurrent assertion wrappers shared by the low-pass FIR block.
// ---------------------------------------------------------------------------
`ifndef FIR_LOWPASS_31TAP_Q15_DEFINES_SVH
`define FIR_LOWPASS_31TAP_Q15_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define FLQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fir_lp_pkg.sv =====
// ---------------------------------------------------------------------------
// fir_lp_pkg
// Shared types, microcode program and coefficient table of the Q15 low-pass
// FIR filter.
// ---------------------------------------------------------------------------
package fir_lp_pkg;

  localparam int unsigned TAP_COUNT  = 31;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned FRAC_W     = 15;
  localparam int unsigned COEF_IDX_W = 5;
  localparam int unsigned STEP_W     = 2;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_FETCH = 2'd0;
  localparam step_t STEP_MAC   = 2'd1;
  localparam step_t STEP_EMIT  = 2'd2;

  typedef enum logic [1:0] {
    COND_IN_VALID,
    COND_TAP_LAST,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  take_in;
    logic  mac;
    logic  emit;
    cond_e cond;
    step_t jump;
  } uword_t;

  typedef struct packed {
    logic load;
    logic mac;
  } dp_ctl_t;

  // Stay on a step until its condition holds, then jump.
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    w = '{take_in: 1'b1, mac: 1'b0, emit: 1'b0, cond: COND_IN_VALID, jump: STEP_MAC};
    case (step)
      STEP_FETCH: w = '{take_in: 1'b1, mac: 1'b0, emit: 1'b0,
                        cond: COND_IN_VALID, jump: STEP_MAC};
      STEP_MAC:   w = '{take_in: 1'b0, mac: 1'b1, emit: 1'b0,
                        cond: COND_TAP_LAST, jump: STEP_EMIT};
      STEP_EMIT:  w = '{take_in: 1'b0, mac: 1'b0, emit: 1'b1,
                        cond: COND_OUT_FREE, jump: STEP_FETCH};
      default:    w = '{take_in: 1'b0, mac: 1'b0, emit: 1'b0,
                        cond: COND_IN_VALID, jump: STEP_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] lp_coeff(logic [COEF_IDX_W-1:0] k);
    logic signed [SAMPLE_W-1:0] c;
    c = '0;
    case (k)
      5'd0,  5'd30: c = -16'sd39;
      5'd1,  5'd29: c = -16'sd67;
      5'd2,  5'd28: c = -16'sd68;
      5'd4,  5'd26: c = 16'sd157;
      5'd5,  5'd25: c = 16'sd323;
      5'd6,  5'd24: c = 16'sd326;
      5'd8,  5'd22: c = -16'sd615;
      5'd9,  5'd21: c = -16'sd1186;
      5'd10, 5'd20: c = -16'sd1136;
      5'd12, 5'd18: c = 16'sd2244;
      5'd13, 5'd17: c = 16'sd5008;
      5'd14, 5'd16: c = 16'sd7302;
      5'd15:        c = 16'sd8192;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/fir_lp_datapath.sv =====
// ---------------------------------------------------------------------------
// fir_lp_datapath
// Circular delay line, shared multiply-accumulate unit and output
// shift/saturation of the Q15 low-pass FIR filter.
// ---------------------------------------------------------------------------
module fir_lp_datapath import fir_lp_pkg::*; #(
  parameter int unsigned TapCount = TAP_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_ctl_t                    ctl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       tap_last_o,
  output logic signed [SAMPLE_W-1:0] result_o
);

  localparam int unsigned IdxW = $clog2(TapCount);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TapCount - 1);

  logic signed [SAMPLE_W-1:0] hist_q [TapCount];
  logic [IdxW-1:0]            wptr_q, ridx_q, tap_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [SAMPLE_W-1:0] coef;
  logic signed [ACC_W-1:0]    prod;
  logic signed [ACC_W-FRAC_W-1:0] shifted;

  assign coef  = lp_coeff(COEF_IDX_W'(tap_q));
  assign prod  = ACC_W'(coef) * ACC_W'(hist_q[ridx_q]);
  assign acc_d = acc_q + prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TapCount; i++) begin
        hist_q[i] <= '0;
      end
      wptr_q <= '0;
    end else if (ctl_i.load) begin
      hist_q[wptr_q] <= sample_i;
      wptr_q         <= (wptr_q == IdxLast) ? '0 : wptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ridx_q <= wptr_q;
      tap_q  <= '0;
      acc_q  <= '0;
    end else if (ctl_i.mac) begin
      ridx_q <= (ridx_q == '0) ? IdxLast : ridx_q - 1'b1;
      tap_q  <= tap_q + 1'b1;
      acc_q  <= acc_d;
    end
  end

  assign tap_last_o = (tap_q == IdxLast);
  assign shifted    = acc_q[ACC_W-1:FRAC_W];

  always_comb begin
    if (shifted[ACC_W-FRAC_W-1] != shifted[SAMPLE_W-1]) begin
      result_o = shifted[ACC_W-FRAC_W-1] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      result_o = shifted[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== design/fir_lowpass_31tap_q15.sv =====
// ---------------------------------------------------------------------------
// fir_lowpass_31tap_q15
// 31-tap Q15 low-pass FIR filter run by a three-step microcode program.
// ---------------------------------------------------------------------------
// channel | ports                           | direction
// input   | in_valid_i, in_stall_o, sample_in_i   | into block
// output  | out_valid_o, out_stall_i, sample_out_o | out of block
//
// A transaction loads the sample, passes every tap through the
// single shared 16x16 multiply-accumulate unit, then stores the result.
// Reset clears the delay line and write pointer at once; no clearing pass.
// A stalled output holds the program in its store step; a new input
// transaction is taken while the previous result still waits.
// ---------------------------------------------------------------------------
`include "fir_lowpass_31tap_q15_defines.svh"

module fir_lowpass_31tap_q15 import fir_lp_pkg::*; #(
  parameter int unsigned TapCount = TAP_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  step_t   step_q, step_d;
  uword_t  uw;
  dp_ctl_t ctl;
  logic    cond_met, tap_last, emit;
  logic    out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_q, result;

  fir_lp_datapath #(
    .TapCount(TapCount)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sample_i   (sample_in_i),
    .tap_last_o (tap_last),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= result;
    end
  end

  always_comb begin
    uw = ucode_rom(step_q);
    case (uw.cond)
      COND_IN_VALID: cond_met = in_valid_i;
      COND_TAP_LAST: cond_met = tap_last;
      COND_OUT_FREE: cond_met = !out_valid_q || !out_stall_i;
      default:       cond_met = 1'b0;
    endcase
    step_d    = cond_met ? uw.jump : step_q;
    ctl.load  = uw.take_in && in_valid_i;
    ctl.mac   = uw.mac;
    emit      = uw.emit && cond_met;
    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  assign in_stall_o   = !uw.take_in;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  `FLQ_ASSERT_NEXT(a_accept_starts_mac, clk_i, rst_ni, in_valid_i && !in_stall_o, step_q == STEP_MAC, "accepted transaction did not start the MAC loop")
  `FLQ_ASSERT(a_no_overwrite, clk_i, rst_ni, !(emit && out_valid_q && out_stall_i), "result overwritten while output stalled")
  `FLQ_ASSERT_NEXT(a_mac_exit_to_emit, clk_i, rst_ni, step_q == STEP_MAC && tap_last, step_q == STEP_EMIT, "MAC loop did not end after the last tap")
  `FLQ_ASSERT(a_valid_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(step_q) == STEP_EMIT, "output valid raised outside the store step")

endmodule
